// File: src/sha1_pkg.sv
// SHA-1 hasher package: constants, command/status structs, round helpers.
// No dependencies.
package sha1_pkg;
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam int ROUNDS = 80;
  localparam int CNT_W = 61;

  // block word source when writing a byte slot
  typedef enum logic [1:0] {
    SRC_DATA = 2'd0,
    SRC_PAD  = 2'd1,
    SRC_ZERO = 2'd2
  } byte_src_t;

  typedef struct packed {
    logic      put_byte;   // write one byte into block at fill position
    byte_src_t src;
    logic      count_byte; // bump message length
    logic      put_len;    // write length into words 14,15
    logic      start;      // load working words, round 0
    logic      round;      // run one round
    logic      finish;     // add working words into chaining words
    logic      rearm;      // reload initial values, clear counts
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       last_round;
  } dp_stat_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction
endpackage

// File: src/sha1_if.sv
// Valid/ready stream interface for the SHA-1 hasher.
// Uses no package.
interface sha1_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;
  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha1_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [31:0] digest_word0;
  logic [31:0] digest_word1;
  logic [31:0] digest_word2;
  logic [31:0] digest_word3;
  logic [31:0] digest_word4;
  modport source (output valid, digest_word0, digest_word1, digest_word2, digest_word3,
                  digest_word4, input ready);
  modport sink (input valid, digest_word0, digest_word1, digest_word2, digest_word3,
                digest_word4, output ready);
endinterface

// File: src/sha1_message_hasher_core.sv
// SHA-1 hasher top level: controller, datapath and stream ports.
// Depends on sha1_pkg, sha1_if, sha1_ctrl, sha1_datapath.
// The 64th byte of a block starts a compression (load, 80 rounds of the
// single round unit, chaining add); input is held off while it runs.
// End of message adds the padding bytes, a length write and one or two
// compressions; the digest is valid the cycle after the last chaining add.
// The digest waits in an output register; the next message runs up to its
// length write meanwhile. Input is held off after a digest while the
// datapath rearms.
// Synchronous reset loads the initial hash values and clears all counts.
module sha1_message_hasher_core import sha1_pkg::*; (
  input logic clk,
  input logic rst,
  sha1_in_if.sink    in_ch,
  sha1_out_if.source out_ch
);
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [159:0] digest;
  logic [159:0] dig_q;
  logic ov;

  sha1_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .byte_present(in_ch.byte_present), .end_of_message(in_ch.end_of_message),
    .stat, .cmd, .out_valid(ov), .out_ready(out_ch.ready)
  );

  // digest is latched in the rearm cycle, right after the final chaining add
  always_ff @(posedge clk) begin
    if (cmd.rearm) dig_q <= digest;
  end

  sha1_datapath u_dp (
    .clk, .rst, .cmd(cmd), .data_byte(in_ch.data_byte), .stat, .digest
  );

  logic [159:0] dsel;
  assign dsel = cmd.rearm ? digest : dig_q;
  assign out_ch.valid = ov;
  assign out_ch.digest_word0 = dsel[159:128];
  assign out_ch.digest_word1 = dsel[127:96];
  assign out_ch.digest_word2 = dsel[95:64];
  assign out_ch.digest_word3 = dsel[63:32];
  assign out_ch.digest_word4 = dsel[31:0];
endmodule

// File: src/sha1_datapath.sv
// SHA-1 datapath: block buffer, rolling schedule, round unit, chaining words.
// Depends on sha1_pkg.
module sha1_datapath import sha1_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  dp_cmd_t      cmd,
  input  logic [7:0]   data_byte,
  output dp_stat_t     stat,
  output logic [159:0] digest
);
  logic [31:0] blk [16];
  logic [31:0] hw [5];
  logic [31:0] a, b, c, d, e;
  logic [5:0] fill;
  logic [CNT_W-1:0] count;
  logic [6:0] rnd;
  logic [7:0] bval;
  logic [31:0] f, k, t, wnew;
  logic [63:0] bits;

  assign stat.fill = fill;
  assign stat.last_round = (rnd == 7'(ROUNDS - 1));
  assign digest = {hw[0], hw[1], hw[2], hw[3], hw[4]};
  assign bits = {count, 3'b000};

  always_comb begin
    case (cmd.src)
      SRC_DATA: bval = data_byte;
      SRC_PAD:  bval = 8'h80;
      default:  bval = 8'h00;
    endcase
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d); k = K0;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d; k = K1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d); k = K2;
    end else begin
      f = b ^ c ^ d; k = K3;
    end
    // schedule word for this round sits in blk[0]; build the word 16 ahead
    wnew = rotl(blk[13] ^ blk[8] ^ blk[2] ^ blk[0], 1);
    t = rotl(a, 5) + f + e + k + blk[0];
  end

  always_ff @(posedge clk) begin
    if (cmd.put_byte) begin
      case (fill[1:0])
        2'd0: blk[fill[5:2]] <= {bval, 24'h0};
        2'd1: blk[fill[5:2]][23:16] <= bval;
        2'd2: blk[fill[5:2]][15:8] <= bval;
        default: blk[fill[5:2]][7:0] <= bval;
      endcase
    end
    if (cmd.put_len) begin
      blk[14] <= bits[63:32];
      blk[15] <= bits[31:0];
    end
    if (cmd.round) begin
      for (int i = 0; i < 15; i++) blk[i] <= blk[i+1];
      blk[15] <= wnew;
      a <= t; b <= a; c <= rotl(b, 30); d <= c; e <= d;
    end
    if (cmd.start) begin
      a <= hw[0]; b <= hw[1]; c <= hw[2]; d <= hw[3]; e <= hw[4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.rearm) begin
      hw[0] <= H0; hw[1] <= H1; hw[2] <= H2; hw[3] <= H3; hw[4] <= H4;
      fill <= '0;
      count <= '0;
      rnd <= '0;
    end else begin
      if (cmd.put_byte) fill <= fill + 6'd1;
      if (cmd.count_byte) count <= count + 1'b1;
      if (cmd.start) rnd <= '0;
      else if (cmd.round) rnd <= rnd + 7'd1;
      if (cmd.finish) begin
        hw[0] <= hw[0] + a; hw[1] <= hw[1] + b; hw[2] <= hw[2] + c;
        hw[3] <= hw[3] + d; hw[4] <= hw[4] + e;
      end
    end
  end
endmodule

// File: src/sha1_ctrl.sv
// SHA-1 controller: byte intake, padding sequence, compression sequencing.
// Depends on sha1_pkg.
module sha1_ctrl import sha1_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     byte_present,
  input  logic     end_of_message,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     out_valid,
  input  logic     out_ready
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PAD   = 7'b0000010, // write 0x80
    S_ZERO  = 7'b0000100, // zero fill
    S_LEN   = 7'b0001000,
    S_START = 7'b0010000,
    S_ROUND = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic pend_end, pend_end_next; // message end pending
  logic final_blk, final_blk_next; // current compression carries length
  logic pad_tail, pad_tail_next; // padding ran to block end: a zero/length block follows
  logic clr_pend, clr_pend_next; // rearm datapath after a digest
  logic ov_next;
  logic acc;

  assign in_ready = (state == S_IDLE) && !clr_pend;
  assign acc = in_valid && in_ready;

  always_comb begin
    state_next = state;
    pend_end_next = pend_end;
    final_blk_next = final_blk;
    pad_tail_next = pad_tail;
    clr_pend_next = 1'b0;
    ov_next = out_valid && !out_ready;
    cmd = '0;
    cmd.src = SRC_ZERO;
    cmd.rearm = clr_pend;
    case (state)
      S_IDLE: begin
        if (acc) begin
          pend_end_next = end_of_message;
          if (byte_present) begin
            cmd.put_byte = 1'b1;
            cmd.src = SRC_DATA;
            cmd.count_byte = 1'b1;
            if (stat.fill == 6'd63) begin
              final_blk_next = 1'b0;
              state_next = S_START;
            end else if (end_of_message) state_next = S_PAD;
          end else if (end_of_message) state_next = S_PAD;
        end
      end
      S_PAD: begin
        cmd.put_byte = 1'b1;
        cmd.src = SRC_PAD;
        pend_end_next = 1'b0;
        if (stat.fill == 6'd55) state_next = S_LEN;
        else if (stat.fill == 6'd63) begin
          final_blk_next = 1'b0;
          pad_tail_next = 1'b1;
          state_next = S_START;
        end else state_next = S_ZERO;
      end
      S_ZERO: begin
        cmd.put_byte = 1'b1;
        if (stat.fill == 6'd55) state_next = S_LEN;
        else if (stat.fill == 6'd63) begin
          final_blk_next = 1'b0;
          pad_tail_next = 1'b1;
          state_next = S_START;
        end
      end
      S_LEN: begin
        cmd.put_len = 1'b1;
        // last compression starts only once the output slot is free
        if (!out_valid || out_ready) begin
          final_blk_next = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (stat.last_round) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        if (final_blk) begin
          final_blk_next = 1'b0;
          clr_pend_next = 1'b1;
          ov_next = 1'b1;
          state_next = S_IDLE;
        end else if (pend_end) state_next = S_PAD;
        else if (pad_tail) begin
          pad_tail_next = 1'b0;
          state_next = S_ZERO;
        end else state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend_end <= 1'b0;
      final_blk <= 1'b0;
      pad_tail <= 1'b0;
      clr_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend_end <= pend_end_next;
      final_blk <= final_blk_next;
      pad_tail <= pad_tail_next;
      clr_pend <= clr_pend_next;
      out_valid <= ov_next;
    end
  end
endmodule
